// ===== rtl/core/jpd_pkg.sv =====
`timescale 1ns / 1ps

package jpd_pkg;

  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned PayloadBytes  = 6;
  localparam int unsigned PosWidth      = 3;
  localparam int unsigned RecordWidth   = 80;
  localparam int unsigned ApbAddrWidth  = 3;
  localparam int unsigned ApbDataWidth  = 32;

  localparam logic [ByteWidth-1:0] PktHeader   = 8'hFF;
  localparam logic [ByteWidth-1:0] SumGood     = 8'hFF;
  localparam logic [ByteWidth-1:0] AxisOffset  = 8'h80;
  localparam logic [PosWidth-1:0]  LastDataPos = 3'd5;
  localparam logic [PosWidth-1:0]  ChecksumPos = 3'd6;

  // register index taken from the word address bit
  localparam logic RegSwapSticks = 1'b0;

  typedef logic [ByteWidth-1:0] byte_t;

  typedef struct packed {
    logic  [7:0]  extension_byte;
    logic  [7:0]  button_bits;
    logic  [15:0] tilt_word;
    logic  [15:0] pan_word;
    logic signed [7:0] left_horizontal;
    logic signed [7:0] left_vertical;
    logic signed [7:0] right_horizontal;
    logic signed [7:0] right_vertical;
  } record_t;

  // byte minus 128 in two's complement
  function automatic logic signed [7:0] axis_of(input byte_t b);
    axis_of = signed'(b ^ AxisOffset);
  endfunction

endpackage

// ===== rtl/core/jpd_frame_parser.sv =====
`timescale 1ns / 1ps

module jpd_frame_parser import jpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    byte_valid_i,
  input  byte_t   byte_i,
  input  logic    advance_i,
  input  logic    swap_sticks_i,
  output logic    emit_o,
  output record_t record_o
);

  logic                hunting_q, hunting_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  byte_t               sum_q, sum_d;
  byte_t               sum_next;
  byte_t               store_q [PayloadBytes];
  logic                store_we;

  assign sum_next = sum_q + byte_i;

  always_comb begin
    hunting_d = hunting_q;
    pos_d     = pos_q;
    sum_d     = sum_q;
    store_we  = 1'b0;
    emit_o    = 1'b0;
    if (byte_valid_i) begin
      if (hunting_q) begin
        if (byte_i == PktHeader) begin
          hunting_d = 1'b0;
          pos_d     = '0;
          sum_d     = '0;
        end
      end else if (pos_q == '0) begin
        // repeated header in the first data slot is skipped
        if (byte_i != PktHeader) begin
          store_we = 1'b1;
          sum_d    = sum_next;
          pos_d    = pos_q + PosWidth'(1);
        end
      end else begin
        store_we = (pos_q <= LastDataPos);
        sum_d    = sum_next;
        if (pos_q == ChecksumPos) begin
          hunting_d = 1'b1;
          pos_d     = '0;
          emit_o    = (sum_next == SumGood);
        end else begin
          pos_d = pos_q + PosWidth'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunting_q <= 1'b1;
      pos_q     <= '0;
      sum_q     <= '0;
    end else if (advance_i) begin
      hunting_q <= hunting_d;
      pos_q     <= pos_d;
      sum_q     <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && store_we) begin
      store_q[pos_q] <= byte_i;
    end
  end

  // record decode from the stored payload
  always_comb begin
    if (swap_sticks_i) begin
      record_o.right_vertical   = axis_of(store_q[2]);
      record_o.right_horizontal = axis_of(store_q[3]);
      record_o.left_vertical    = axis_of(store_q[0]);
      record_o.left_horizontal  = axis_of(store_q[1]);
    end else begin
      record_o.right_vertical   = axis_of(store_q[0]);
      record_o.right_horizontal = axis_of(store_q[1]);
      record_o.left_vertical    = axis_of(store_q[2]);
      record_o.left_horizontal  = axis_of(store_q[3]);
    end
    record_o.pan_word       = {store_q[0], store_q[1]};
    record_o.tilt_word      = {store_q[2], store_q[3]};
    record_o.button_bits    = store_q[4];
    record_o.extension_byte = store_q[5];
  end

endmodule

// ===== rtl/core/jpd_rec_reg.sv =====
`timescale 1ns / 1ps

module jpd_rec_reg import jpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  record_t record_i,
  input  logic    ready_i,
  output logic    valid_o,
  output logic    free_o,
  output record_t record_o
);

  logic    valid_q;
  record_t record_q;

  // slot frees up in the same cycle its record is taken
  assign free_o   = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign record_o = record_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      record_q <= record_i;
    end
  end

endmodule

// ===== rtl/core/joystick_packet_deframer_core.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata[7:0]  rx_byte
// m_axis    out  m_axis_tvalid/tready      tdata[79:0] decoded record
// apb       in   psel/penable/pwrite       reg 0 swap_sticks at byte address 0
//
// one byte per cycle unless a held record stalls; bytes pass the input register, and
// m_axis_tvalid_o is registered and set as a good packet's checksum byte moves on
// reset (rst_ni, async low) starts hunting for a header with empty registers
// a held record stalls parsing only when a second good packet completes
// before it is taken; the input register then holds its byte

module joystick_packet_deframer_core import jpd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // byte stream in
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [7:0]              s_axis_tdata_i,   // [7:0] rx_byte
  // record stream out
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // [7:0] right_vertical, [15:8] right_horizontal, [23:16] left_vertical,
  // [31:24] left_horizontal, [47:32] pan_word, [63:48] tilt_word,
  // [71:64] button_bits, [79:72] extension_byte
  output logic [RecordWidth-1:0]  m_axis_tdata_o,
  // configuration
  input  logic                    psel_i,
  input  logic                    penable_i,
  input  logic                    pwrite_i,
  input  logic [ApbAddrWidth-1:0] paddr_i,
  input  logic [ApbDataWidth-1:0] pwdata_i,
  output logic [ApbDataWidth-1:0] prdata_o,
  output logic                    pready_o
);

  logic    swap_sticks_q;
  logic    in_valid_q;
  byte_t   in_byte_q;
  logic    emit;
  logic    out_free;
  logic    advance;
  record_t record;
  record_t out_record;

  // apb register, always ready
  assign pready_o = 1'b1;
  assign prdata_o = {{(ApbDataWidth-1){1'b0}}, swap_sticks_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_sticks_q <= 1'b0;
    end else if (psel_i && penable_i && pwrite_i && (paddr_i[2] == RegSwapSticks)) begin
      swap_sticks_q <= pwdata_i[0];
    end
  end

  // held byte moves on unless it completes a good packet with the output slot full
  assign advance         = in_valid_q && (!emit || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  jpd_frame_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (in_valid_q),
    .byte_i        (in_byte_q),
    .advance_i     (advance),
    .swap_sticks_i (swap_sticks_q),
    .emit_o        (emit),
    .record_o      (record)
  );

  jpd_rec_reg u_rec_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && emit),
    .record_i (record),
    .ready_i  (m_axis_tready_i),
    .valid_o  (m_axis_tvalid_o),
    .free_o   (out_free),
    .record_o (out_record)
  );

  assign m_axis_tdata_o = out_record;

endmodule
